// File: rtl/shcb_pkg.sv
// Shared types and constants for the strip hit cluster builder.
// Used by shcb_cell and strip_hit_cluster_builder_top; no dependencies.
package shcb_pkg;

    // Field widths of one hit, the result and the configuration
    localparam int CHIP_W   = 5;
    localparam int CHAN_W   = 8;
    localparam int FEM_W    = 4;
    localparam int FPGA_W   = 4;
    localparam int XING_W   = 7;
    localparam int AMP_W    = 7;
    localparam int MOD_W    = 6;
    localparam int ADC_W    = 3;
    localparam int STAT_W   = 2;
    localparam int CNTO_W   = 5;
    localparam int VOLT_W   = 15;
    localparam int HV_W     = 11;
    localparam int DAC_W    = 8;
    localparam int NUM_DAC  = 8;
    localparam int CFG_IDX_W = 8;

    // Packed stream widths
    localparam int S_DATA_W = 48;
    localparam int HIT_W    = 46;
    localparam int M_DATA_W = 32;
    localparam int RES_W    = 26;

    // Hit quality limits
    localparam logic [CHIP_W-1:0] CHIP_MAX     = 5'd27;
    localparam logic [CHAN_W-1:0] CHAN_MAX     = 8'd128;
    localparam logic [CHAN_W-1:0] CHAN_EDGE    = 8'd128;
    localparam logic [CHIP_W-1:0] CHIP_GAP     = 5'd13;
    localparam logic [MOD_W-1:0]  MOD_UNMAPPED = 6'h3F;

    // Voltage arithmetic
    localparam logic [HV_W-1:0]   VOLT_BASE = 11'd200;
    localparam logic [VOLT_W-1:0] VOLT_MAX  = 15'd32767;

    // Request kinds on tuser
    localparam logic FUNC_LOAD = 1'b0;

    // Hit status codes
    localparam logic [STAT_W-1:0] ST_UNCLUSTERED = 2'd0;
    localparam logic [STAT_W-1:0] ST_SEED        = 2'd1;
    localparam logic [STAT_W-1:0] ST_ABSORBED    = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOISE       = 2'd3;

    // One incoming hit, lowest field last
    typedef struct packed {
        logic               absorbed;
        logic               force_ignore;
        logic [ADC_W-1:0]   adc;
        logic [MOD_W-1:0]   module_number;
        logic [AMP_W-1:0]   amplitude;
        logic [XING_W-1:0]  crossing;
        logic [FPGA_W-1:0]  fpga;
        logic [FEM_W-1:0]   fem;
        logic [CHAN_W-1:0]  channel;
        logic [CHIP_W-1:0]  chip;
    } hit_t;

    // Control broadcast to every member cell
    typedef struct packed {
        logic probe;   // latch neighbor flag against the probe channel
        logic shift;   // move member channels one cell down the row
    } cell_ctl_t;

endpackage

// File: rtl/shcb_cell.sv
// One member cell: holds one cluster channel and flags a probe channel next to it.
// Depends on shcb_pkg.
module shcb_cell (
    input  logic                          aclk,
    input  shcb_pkg::cell_ctl_t           ctl,
    input  logic                          held,
    input  logic [shcb_pkg::CHAN_W-1:0]   probe_chan,
    input  logic [shcb_pkg::CHAN_W-1:0]   chan_in,
    output logic [shcb_pkg::CHAN_W-1:0]   chan_out,
    output logic                          near_out
);

    logic [shcb_pkg::CHAN_W-1:0] chan_reg;
    logic [shcb_pkg::CHAN_W-1:0] chan_next;
    logic                        near_reg;
    logic                        near_next;
    logic [shcb_pkg::CHAN_W:0]   chan_up;
    logic [shcb_pkg::CHAN_W:0]   probe_up;

    // Compare stored and probe channel for a distance of one
    always_comb begin
        chan_up  = {1'b0, chan_reg} + 1'b1;
        probe_up = {1'b0, probe_chan} + 1'b1;
        near_next = near_reg;
        if (ctl.probe) begin
            near_next = held && ((chan_up == {1'b0, probe_chan}) ||
                                 (probe_up == {1'b0, chan_reg}));
        end
        chan_next = ctl.shift ? chan_in : chan_reg;
    end

    // Hold channel and flag; advance the channel on shift
    always_ff @(posedge aclk) begin
        chan_reg <= chan_next;
        near_reg <= near_next;
    end

    assign chan_out = chan_reg;
    assign near_out = near_reg;

endmodule

// File: rtl/strip_hit_cluster_builder_top.sv
// Top level of the strip hit cluster builder: seed registers, control and a row
// of member cells. Depends on shcb_pkg and shcb_cell.
//
// Usage:
//   s_ channel carries one hit per request; s_tuser is the kind (0 load the
//   hit as a new seed, 1 offer it as a candidate), s_tdata the hit fields.
//   m_ channel returns exactly one result per request, in order.
//   cfg_ channel writes the eight DAC code registers (index 0..7); writes to
//   other indexes are taken and dropped. cfg_ready is always high.
// Timing:
//   A request is taken while its channel is compared against every held
//   member cell at once; the commit that follows, once the output register
//   frees, resolves the join, updates the cluster and loads the output register.
//   m_tvalid rises when that register loads, and the take-then-commit sequence
//   over the cell row means no new request is taken until the last one commits.
// Reset and stall:
//   aresetn (synchronous, low) clears the seed to noise with no members,
//   the voltage sum and the DAC codes. While m_tready is low the result
//   holds, one further request may be taken and evaluated, and its commit
//   waits until the output register frees.
module strip_hit_cluster_builder_top #(
    parameter int MAX_MEMBERS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Hit input
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // chip[4:0] channel[12:5] fem[16:13] fpga[20:17] crossing[27:21]
    // amplitude[34:28] module_number[40:35] adc[43:41] force_ignore[44]
    // already_absorbed[45], zero fill [47:46]
    input  logic [shcb_pkg::S_DATA_W-1:0]   s_tdata,
    // func[0]
    input  logic                            s_tuser,
    // Result output
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // joined[0] seed_status[2:1] candidate_status[4:3] member_count[9:5]
    // voltage_sum[24:10] list_full[25], zero fill [31:26]
    output logic [shcb_pkg::M_DATA_W-1:0]   m_tdata,
    // Configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [shcb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [shcb_pkg::DAC_W-1:0]      cfg_data
);

    localparam int CNT_W = $clog2(MAX_MEMBERS + 1);
    localparam logic [shcb_pkg::CHIP_W-1:0] CHIP_ONE = 5'd1;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EVAL = 2'b10
    } fsm_t;

    fsm_t                          state_reg, state_next;
    shcb_pkg::hit_t                hit_in;
    shcb_pkg::hit_t                hit_reg;
    logic                          func_reg;
    logic [shcb_pkg::DAC_W-1:0]    dac_reg [shcb_pkg::NUM_DAC];

    logic [shcb_pkg::CHIP_W-1:0]   seed_chip_reg;
    logic [shcb_pkg::CHAN_W-1:0]   seed_chan_reg;
    logic [shcb_pkg::FEM_W-1:0]    seed_fem_reg;
    logic [shcb_pkg::FPGA_W-1:0]   seed_fpga_reg;
    logic [shcb_pkg::XING_W-1:0]   seed_xing_reg;
    logic [shcb_pkg::STAT_W-1:0]   seed_state_reg, seed_state_next;
    logic [CNT_W-1:0]              count_reg, count_next;
    logic [shcb_pkg::VOLT_W-1:0]   volt_reg, volt_next;

    logic                          m_valid_reg, m_valid_next;
    logic [shcb_pkg::RES_W-1:0]    out_reg, out_next;

    shcb_pkg::cell_ctl_t           cell_ctl;
    logic [shcb_pkg::CHAN_W-1:0]   chan_link [MAX_MEMBERS+1];
    logic [MAX_MEMBERS-1:0]        near_vec;

    logic                          accept;
    logic                          commit;
    logic                          noise;
    logic                          usable;
    logic                          match;
    logic                          near;
    logic                          full;
    logic                          joined;
    logic                          list_full;
    logic [shcb_pkg::STAT_W-1:0]   cand_stat;
    logic [shcb_pkg::CHIP_W-1:0]   chip_diff;
    logic [shcb_pkg::HV_W-1:0]     hit_volt;
    logic [shcb_pkg::VOLT_W:0]     volt_sum;
    logic [CNT_W+4:0]              count_wide;

    // Unpack the request
    assign hit_in   = shcb_pkg::hit_t'(s_tdata[shcb_pkg::HIT_W-1:0]);
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign commit   = (state_reg == ST_EVAL) && (!m_valid_reg || m_tready);
    assign cfg_ready = 1'b1;

    // Member cell row: probe on accept, shift a new member in on a commit that loads or joins
    assign cell_ctl.probe = accept;
    assign cell_ctl.shift = commit && ((func_reg == shcb_pkg::FUNC_LOAD) || joined);
    assign chan_link[0]   = hit_reg.channel;

    for (genvar i = 0; i < MAX_MEMBERS; i++) begin : g_cell
        shcb_cell u_cell (
            .aclk       (aclk),
            .ctl        (cell_ctl),
            .held       (CNT_W'(i) < count_reg),
            .probe_chan (hit_in.channel),
            .chan_in    (chan_link[i]),
            .chan_out   (chan_link[i+1]),
            .near_out   (near_vec[i])
        );
    end

    // Resolve the held request against the seed
    always_comb begin
        noise = hit_reg.force_ignore || (hit_reg.chip > shcb_pkg::CHIP_MAX) ||
                (hit_reg.channel > shcb_pkg::CHAN_MAX) ||
                (hit_reg.amplitude != '0) ||
                (hit_reg.module_number == shcb_pkg::MOD_UNMAPPED);
        usable = (seed_state_reg == shcb_pkg::ST_UNCLUSTERED) ||
                 (seed_state_reg == shcb_pkg::ST_SEED);
        match = usable && !noise && !hit_reg.absorbed &&
                (seed_xing_reg == hit_reg.crossing) &&
                (seed_fem_reg == hit_reg.fem) && (seed_fpga_reg == hit_reg.fpga);
        chip_diff = (seed_chip_reg > hit_reg.chip) ? seed_chip_reg - hit_reg.chip
                                                    : hit_reg.chip - seed_chip_reg;
        near = match && (((seed_chip_reg == hit_reg.chip) && (|near_vec)) ||
                         ((seed_chan_reg == hit_reg.channel) &&
                          (chip_diff == CHIP_ONE)) ||
                         ((chip_diff == shcb_pkg::CHIP_GAP) &&
                          (seed_chan_reg == shcb_pkg::CHAN_EDGE) &&
                          (hit_reg.channel == shcb_pkg::CHAN_EDGE)));
        full = (count_reg >= CNT_W'(MAX_MEMBERS));
        hit_volt = shcb_pkg::VOLT_BASE + {1'b0, dac_reg[hit_reg.adc], 2'b00};
        volt_sum = {1'b0, volt_reg} + (shcb_pkg::VOLT_W + 1)'(hit_volt);

        joined    = 1'b0;
        list_full = 1'b0;
        cand_stat = shcb_pkg::ST_UNCLUSTERED;
        seed_state_next = seed_state_reg;
        count_next = count_reg;
        volt_next  = volt_reg;

        if (func_reg == shcb_pkg::FUNC_LOAD) begin
            seed_state_next = (noise || hit_reg.absorbed) ? shcb_pkg::ST_NOISE
                                                          : shcb_pkg::ST_UNCLUSTERED;
            count_next = CNT_W'(1);
            volt_next  = shcb_pkg::VOLT_W'(hit_volt);
        end else begin
            if (near && full) begin
                list_full = 1'b1;
            end else if (near) begin
                joined = 1'b1;
                count_next = count_reg + 1'b1;
                volt_next = volt_sum[shcb_pkg::VOLT_W] ? shcb_pkg::VOLT_MAX
                                                       : volt_sum[shcb_pkg::VOLT_W-1:0];
                seed_state_next = shcb_pkg::ST_SEED;
            end
            priority if (noise) begin
                cand_stat = shcb_pkg::ST_NOISE;
            end else if (hit_reg.absorbed || joined) begin
                cand_stat = shcb_pkg::ST_ABSORBED;
            end else begin
                cand_stat = shcb_pkg::ST_UNCLUSTERED;
            end
        end

        count_wide = {5'b0, count_next};
        out_next = {list_full, volt_next, count_wide[shcb_pkg::CNTO_W-1:0],
                    cand_stat, seed_state_next, joined};
    end

    // Sequence: take a request, then commit it when the output frees
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (commit) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        m_valid_next = commit ? 1'b1 : (m_valid_reg && !m_tready);
    end

    // Control and cluster state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            m_valid_reg    <= 1'b0;
            seed_state_reg <= shcb_pkg::ST_NOISE;
            count_reg      <= '0;
            volt_reg       <= '0;
            seed_chip_reg  <= '0;
            seed_chan_reg  <= '0;
            seed_fem_reg   <= '0;
            seed_fpga_reg  <= '0;
            seed_xing_reg  <= '0;
            for (int k = 0; k < shcb_pkg::NUM_DAC; k++) begin
                dac_reg[k] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (commit) begin
                seed_state_reg <= seed_state_next;
                count_reg      <= count_next;
                volt_reg       <= volt_next;
                if (func_reg == shcb_pkg::FUNC_LOAD) begin
                    seed_chip_reg <= hit_reg.chip;
                    seed_chan_reg <= hit_reg.channel;
                    seed_fem_reg  <= hit_reg.fem;
                    seed_fpga_reg <= hit_reg.fpga;
                    seed_xing_reg <= hit_reg.crossing;
                end
            end
            if (cfg_valid && (cfg_index < shcb_pkg::CFG_IDX_W'(shcb_pkg::NUM_DAC))) begin
                dac_reg[cfg_index[$clog2(shcb_pkg::NUM_DAC)-1:0]] <= cfg_data;
            end
        end
    end

    // Request and result payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            hit_reg  <= hit_in;
            func_reg <= s_tuser;
        end
        if (commit) begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(shcb_pkg::M_DATA_W - shcb_pkg::RES_W)'(0), out_reg};

endmodule
